FILE: rtl/rqir_pkg.sv
// Shared types and constants for the ring queue with indexed read and remove.
package rqir_pkg;

   localparam int OPCODE_W = 2;
   localparam int EXT_W    = 32;
   localparam int POS_W    = 5;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;
   localparam int WIDE_W   = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_READ   = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic finish;
      logic hold_start;
      logic shift;
      logic remove_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic remove_ok;
      logic shift_more;
      logic shift_more_next;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: rtl/rqir_controller.sv
// Sequencing state machine for the ring queue.
module rqir_controller import rqir_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.remove_ok) begin
               cmd.hold_start = 1'b1;
               state_in       = sts.shift_more ? S_SHIFT : S_RESULT;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (!sts.shift_more_next) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.remove_done = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/rqir_datapath.sv
// Ring store, pointers, request latch and response register of the ring queue.
module rqir_datapath import rqir_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [EXT_W-1:0]    req_push_data,
   input  logic [POS_W-1:0]    req_position,
   input  ctrl_cmd_type        cmd,
   output dp_sts_type          sts,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [EXT_W-1:0]    rsp_result_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW + 1) > POS_W) ? (CW + 1) : POS_W;
   localparam int SW   = AW + POS_W + 1;

   function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec_addr(input logic [AW-1:0] a);
      return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
   endfunction

   logic [WORD_WIDTH-1:0] ring_store [DEPTH];
   logic [WORD_WIDTH-1:0] mem_rdata_ff;

   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   opcode_type            op_ff;
   logic [WORD_WIDTH-1:0] data_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [AW-1:0]         ptr_ff;
   logic [CW-1:0]         idx_ff;
   logic [WORD_WIDTH-1:0] hold_ff;

   logic                  rsp_valid_ff;
   logic [EXT_W-1:0]      rsp_data_ff;
   status_type            rsp_status_ff;
   logic [OCC_W-1:0]      rsp_occ_ff;
   logic                  rsp_empty_ff;

   opcode_type            req_op;
   logic [WIDE_W-1:0]     push_ext;
   logic [POS_W-1:0]      pos_m1;
   logic [CMPW-1:0]       pos_m1_ext;
   logic [SW-1:0]         slot_sum, slot_wrap;
   logic [AW-1:0]         start_slot;

   logic [CMPW-1:0]       cnt_ext, pos_ext, idx_ext, cnt_in_ext;
   logic                  is_full, is_zero, bad_pos, op_ok;
   status_type            op_status;

   logic                  mem_we, mem_re, rsp_load;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [WORD_WIDTH-1:0] mem_wdata, rsp_word;
   logic [WIDE_W-1:0]     rsp_word_ext;
   logic [EXT_W-1:0]      rsp_data_in;
   status_type            rsp_status_in;

   // Slot of the addressed entry, computed from the incoming position.
   always_comb begin
      req_op     = opcode_type'(req_opcode);
      push_ext   = WIDE_W'(req_push_data);
      pos_m1     = req_position - POS_W'(1);
      pos_m1_ext = CMPW'(pos_m1);
      slot_sum   = SW'(head_ff) + SW'(pos_m1);
      slot_wrap  = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
      start_slot = (slot_wrap >= SW'(DEPTH)) ? '0 : slot_wrap[AW-1:0];
   end

   // Checks on the latched transaction against the current occupancy.
   always_comb begin
      cnt_ext = CMPW'(count_ff);
      pos_ext = CMPW'(pos_ff);
      idx_ext = CMPW'(idx_ff);
      is_full = (count_ff == CW'(DEPTH));
      is_zero = (count_ff == '0);
      bad_pos = (pos_ff == '0) || (pos_ext > cnt_ext);
      case (op_ff)
         OP_PUSH: op_status = is_full ? ST_FULL : ST_OK;
         OP_POP:  op_status = is_zero ? ST_EMPTY : ST_OK;
         default: op_status = bad_pos ? ST_BADPOS : ST_OK;
      endcase
      op_ok               = (op_status == ST_OK);
      sts.remove_ok       = (op_ff == OP_REMOVE) && !bad_pos;
      sts.shift_more      = (idx_ext + CMPW'(1)) < cnt_ext;
      sts.shift_more_next = (idx_ext + CMPW'(2)) < cnt_ext;
      sts.out_free        = !rsp_valid_ff || !rsp_stall;
   end

   // Pointer and occupancy updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.finish && op_ok) begin
         case (op_ff)
            OP_PUSH: begin
               tail_in  = inc_addr(tail_ff);
               count_in = count_ff + CW'(1);
            end
            OP_POP: begin
               head_in  = inc_addr(head_ff);
               count_in = count_ff - CW'(1);
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (cmd.remove_done) begin
         tail_in  = dec_addr(tail_ff);
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Memory ports: one write, one registered read.
   always_comb begin
      mem_we    = (cmd.finish && op_ok && (op_ff == OP_PUSH)) || cmd.shift;
      mem_waddr = cmd.shift ? ptr_ff : tail_ff;
      mem_wdata = cmd.shift ? mem_rdata_ff : data_ff;
      mem_re    = cmd.accept || cmd.hold_start || cmd.shift;
      if (cmd.accept) begin
         mem_raddr = ((req_op == OP_PUSH) || (req_op == OP_POP)) ? head_ff : start_slot;
      end else if (cmd.hold_start) begin
         mem_raddr = inc_addr(ptr_ff);
      end else begin
         mem_raddr = inc_addr(inc_addr(ptr_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_store[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= ring_store[mem_raddr];
      end
   end

   // Transaction latch and shift cursor.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         data_ff <= push_ext[WORD_WIDTH-1:0];
         pos_ff  <= req_position;
         ptr_ff  <= start_slot;
         idx_ff  <= pos_m1_ext[CW-1:0];
      end else if (cmd.shift) begin
         ptr_ff <= inc_addr(ptr_ff);
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.hold_start) begin
         hold_ff <= mem_rdata_ff;
      end
   end

   // Response register.
   always_comb begin
      rsp_load = cmd.finish || cmd.remove_done;
      if (cmd.remove_done) begin
         rsp_word      = hold_ff;
         rsp_status_in = ST_OK;
      end else begin
         rsp_word      = (op_ok && (op_ff != OP_PUSH)) ? mem_rdata_ff : '0;
         rsp_status_in = op_status;
      end
      rsp_word_ext = WIDE_W'(rsp_word);
      rsp_data_in  = rsp_word_ext[EXT_W-1:0];
      cnt_in_ext   = CMPW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= cnt_in_ext[OCC_W-1:0];
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_data = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == ((count_ff == '0) || (count_ff == CW'(DEPTH))))
      else $error("head and tail disagree with entry count");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> sts.shift_more)
      else $error("shift runs past the last entry");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> sts.out_free)
      else $error("response overwritten before it was taken");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove_done |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("removal did not shrink the queue");

endmodule

FILE: rtl/ring_queue_indexed_remove_unit.sv
// Top level of the ring queue with indexed read and indexed remove.
//
// Request channel (req_): opcode, push_data, position. A transaction is taken
// when req_valid is high and req_stall is low. Opcodes: push, pop, read the
// entry at a 1-based position from the head, remove the entry at a position.
// Response channel (rsp_): exactly one response per request, in order, with
// the word popped, read or removed (zero otherwise), a status code, the
// occupancy after the operation and an empty flag.
// Path: for push, pop, read and any failed operation, the response is formed
// through the registered read port of the ring store and the response
// register. In a removal at position p with n entries, after the target word
// is read, every later entry moves one slot toward the head, one read and
// one write of the store per cycle.
// One request is in work at a time; req_stall is low only while no request
// is in work. A finished response sits in an output register, so a new
// request is taken while it waits; if rsp_stall holds it, the next request
// stops at its final step until the register frees.
// Reset (synchronous, active high) empties the queue and drops any pending
// response. The store is not cleared: only written entries reach a response.
module ring_queue_indexed_remove_unit import rqir_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [EXT_W-1:0]    req_push_data,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EXT_W-1:0]    rsp_result_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Sequencer: takes the transaction, steps through the shift, closes it.
   rqir_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, pointers and the response register.
   rqir_datapath #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_push_data   (req_push_data),
      .req_position    (req_position),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_data (rsp_result_data),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

FILE: verif/tb.sv
// Testbench for the ring queue with indexed read and remove: stimulus, prediction and checks.
`timescale 1ns / 100ps

module tb;
   import rqir_pkg::*;

   localparam int DEPTH       = 16;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int PHASES      = 4;
   localparam int ITEMS_PHASE = 370;
   // Cycles without any transaction on either channel before the run is abandoned.
   localparam int QUIET_LIMIT = 4000;
   // Settling time after the last response: well above the longest removal.
   localparam int TAIL_CYCLES = 32;

   typedef struct packed {
      opcode_type        op;
      logic [EXT_W-1:0]  word;
      logic [POS_W-1:0]  pos;
   } req_item_type;

   typedef struct packed {
      logic [EXT_W-1:0]  data;
      status_type        status;
      logic [OCC_W-1:0]  occ;
      logic              empty;
   } rsp_item_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode    = '0;
   logic [EXT_W-1:0]    req_push_data = '0;
   logic [POS_W-1:0]    req_position  = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [EXT_W-1:0]    rsp_result_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                rsp_is_empty;

   // Pending requests for the driver and responses still owed by the block.
   req_item_type pending_reqs [$];
   rsp_item_type owed_rsps [$];

   // Idling percentages for the current phase.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int requests_issued   = 0;
   int responses_checked = 0;
   int fail_count        = 0;
   int quiet_cycles      = 0;
   int op_seen [4]       = '{default: 0};
   int status_seen [4]   = '{default: 0};

   // Shadow of the queue contents, kept in step with accepted requests.
   logic [EXT_W-1:0] image_store [DEPTH];
   logic [PTR_W-1:0] image_head  = '0;
   logic [PTR_W-1:0] image_tail  = '0;
   logic [OCC_W-1:0] image_count = '0;

   // Occupancy as the stimulus generator expects it, used to aim positions.
   int planned_count = 0;

   ring_queue_indexed_remove_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_push_data   (req_push_data),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_data (rsp_result_data),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #2 clock = ~clock;

   // Apply one accepted request to the shadow queue and return the response it owes.
   function automatic rsp_item_type apply_request(opcode_type op, logic [EXT_W-1:0] word,
                                                  logic [POS_W-1:0] pos);
      rsp_item_type     r;
      logic [PTR_W-1:0] slot;
      logic [PTR_W-1:0] dst;
      int               k;
      r.data   = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (image_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               image_store[image_tail] = word;
               image_tail  = image_tail + 1'b1;
               image_count = image_count + 1'b1;
            end
         end
         OP_POP: begin
            if (image_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data      = image_store[image_head];
               image_head  = image_head + 1'b1;
               image_count = image_count - 1'b1;
            end
         end
         default: begin
            if (pos == 0 || pos > image_count) begin
               r.status = ST_BADPOS;
            end else begin
               // Position 16 folds to head + 15 in the 4-bit sum, as it should.
               slot   = image_head + pos[PTR_W-1:0] - 1'b1;
               r.data = image_store[slot];
               if (op == OP_REMOVE) begin
                  // Close the gap: move each later entry one slot toward the head.
                  for (k = pos - 1; k + 1 < image_count; k++) begin
                     dst = image_head + PTR_W'(k);
                     image_store[dst] = image_store[dst + 1'b1];
                  end
                  image_tail  = image_tail - 1'b1;
                  image_count = image_count - 1'b1;
               end
            end
         end
      endcase
      r.occ   = image_count;
      r.empty = (image_count == 0);
      return r;
   endfunction

   // Hand one request to the driver and track the occupancy it should lead to.
   task automatic queue_request(opcode_type op, logic [EXT_W-1:0] word, logic [POS_W-1:0] pos);
      req_item_type it;
      it.op   = op;
      it.word = word;
      it.pos  = pos;
      pending_reqs.push_back(it);
      requests_issued++;
      case (op)
         OP_PUSH:   if (planned_count < DEPTH) planned_count++;
         OP_POP:    if (planned_count > 0) planned_count--;
         OP_REMOVE: if (pos != 0 && pos <= planned_count) planned_count--;
         default: ;
      endcase
   endtask

   // Driver: present the next pending transaction once the previous one is taken;
   // hold the payload steady while stalled.
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_valid     <= 1'b1;
            req_opcode    <= nxt.op;
            req_push_data <= nxt.word;
            req_position  <= nxt.pos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on every accepted request, then check every accepted response
   // against the oldest owed one. Both happen here so their order is fixed.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = apply_request(opcode_type'(req_opcode), req_push_data, req_position);
            owed_rsps.push_back(want);
            op_seen[req_opcode]++;
            status_seen[want.status]++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.data   = rsp_result_data;
            got.status = status_type'(rsp_status);
            got.occ    = rsp_occupancy;
            got.empty  = rsp_is_empty;
            responses_checked++;
            if (owed_rsps.size() == 0) begin
               $error("response with none owed: data %0h status %0d", got.data, got.status);
               fail_count++;
            end else begin
               want = owed_rsps.pop_front();
               if (got.data !== want.data) begin
                  $error("rsp_result_data: expected %0h, got %0h", want.data, got.data);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.occ !== want.occ) begin
                  $error("rsp_occupancy: expected %0d, got %0d", want.occ, got.occ);
                  fail_count++;
               end
               if (got.empty !== want.empty) begin
                  $error("rsp_is_empty: expected %0b, got %0b", want.empty, got.empty);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: abandon the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transaction for %0d cycles", QUIET_LIMIT);
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int send_tbl [PHASES]  = '{0, 81, 0, 8};
      int stall_tbl [PHASES] = '{0, 0, 81, 8};
      int phase;
      int i;
      int pick;
      bit fill_bias;
      opcode_type       op;
      logic [POS_W-1:0] pos;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         send_idle_pct  = send_tbl[phase];
         recv_stall_pct = stall_tbl[phase];

         if (phase == 0) begin
            // Empty queue: underflow, and bad positions including zero and the top code.
            queue_request(OP_POP, 32'h0, 5'd0);
            queue_request(OP_READ, 32'h0, 5'd1);
            queue_request(OP_REMOVE, 32'h0, 5'd0);
            queue_request(OP_READ, 32'h0, 5'd31);
            // Fill to the brim with extreme and mixed words, then overflow.
            queue_request(OP_PUSH, 32'h0000_0000, 5'd0);
            queue_request(OP_PUSH, 32'hFFFF_FFFF, 5'd31);
            queue_request(OP_PUSH, 32'hAAAA_AAAA, 5'd0);
            queue_request(OP_PUSH, 32'h5555_5555, 5'd0);
            for (i = 0; i < DEPTH - 4; i++)
               queue_request(OP_PUSH, $urandom, 5'd0);
            queue_request(OP_PUSH, 32'hDEAD_0001, 5'd0);
            // Last valid position, one beyond, longest shift, removal of the tail.
            queue_request(OP_READ, 32'h0, 5'd16);
            queue_request(OP_READ, 32'h0, 5'd17);
            queue_request(OP_REMOVE, 32'h0, 5'd1);
            queue_request(OP_REMOVE, 32'h0, 5'd15);
            queue_request(OP_READ, 32'h0, 5'd0);
            queue_request(OP_POP, 32'h0, 5'd0);
         end

         fill_bias = 1'b1;
         for (i = 0; i < ITEMS_PHASE; i++) begin
            // Swing between filling and draining so both full and empty are reached.
            if (i % 40 == 39)
               fill_bias = !fill_bias;
            pick = $urandom_range(99);
            if (pick < (fill_bias ? 45 : 15))
               op = OP_PUSH;
            else if (pick < (fill_bias ? 60 : 45))
               op = OP_POP;
            else if (pick < 78)
               op = OP_READ;
            else
               op = OP_REMOVE;
            // Mostly aim inside the queue; otherwise any code the field can carry.
            if (planned_count > 0 && $urandom_range(99) < 85)
               pos = POS_W'($urandom_range(1, planned_count));
            else
               pos = POS_W'($urandom_range(0, 31));
            queue_request(op, $urandom, pos);
         end

         // Hold off the next phase until every owed response has come back.
         wait (responses_checked >= requests_issued);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_rsps.size() != 0) begin
         $error("%0d responses never arrived", owed_rsps.size());
         fail_count++;
      end

      $display("covered %0d requests over %0d idling phases: push %0d, pop %0d, read %0d, remove %0d",
               requests_issued, PHASES, op_seen[OP_PUSH], op_seen[OP_POP],
               op_seen[OP_READ], op_seen[OP_REMOVE]);
      $display("outcomes: ok %0d, underflow %0d, overflow %0d, bad position %0d",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
               status_seen[ST_BADPOS]);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/rqir_pkg.sv
rtl/rqir_controller.sv
rtl/rqir_datapath.sv
rtl/ring_queue_indexed_remove_unit.sv
verif/tb.sv
